/* sv/irs_pkg.sv */
`timescale 1ns / 1ps
package irs_pkg;
  localparam int NumCh = 7;
  localparam int StepCh = 6;
  localparam int AxW = 32;
  // input item actions
  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;
  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONFIN   = 2'd1,
    ST_STOPPED  = 2'd2,
    ST_CTRL     = 2'd3
  } status_t;
endpackage

/* sv/imu_running_statistics.sv */
`timescale 1ns / 1ps
// Welford running statistics over six IMU axes and the timestamp step. The block takes
// one item at a time; the action in in_tuser selects a sample update, a clear and start,
// a stop or a plain read, and every item returns one result item with the counts, the
// selected channel's mean, spread, min and max, and the timestamp record. Clear, stop,
// read and dropped samples go through the decode, result and wait states to their result. An
// accepted sample updates the step channel (when the timestamp moved forward) and the six
// axes one after another through a single shared unit: a bit-serial restoring divider
// for the mean step and a shift-add multiplier that spends one cycle per bit of the new
// deviation (at most 49) on the spread term. The result sits in an output register, so
// the next item is taken while it waits; that item's result then waits until the register
// is free.
module imu_running_statistics (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, timestamp_ns
  input  logic [255:0] in_tdata,
  // action[1:0], sample_finite, channel[2:0]
  input  logic [5:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sample_count, channel_count, channel_mean, channel_spread, channel_min,
  // channel_max, nonmonotonic_count, first_time, last_time
  output logic [399:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);
  typedef enum logic [3:0] {
    S_IDLE, S_CH, S_DIV, S_MEAN, S_MUL, S_SUM, S_NEXT, S_RESULT, S_WAIT
  } state_t;

  state_t state_r;
  logic [1:0] action_r;
  logic [irs_pkg::AxW-1:0] axis_r [6];
  logic finite_r;
  logic [63:0] ts_r;
  logic [2:0] chsel_r;

  logic signed [47:0] mean_r [irs_pkg::NumCh];
  logic [63:0] spr_r [irs_pkg::NumCh];
  logic signed [31:0] min_r [irs_pkg::NumCh];
  logic signed [31:0] max_r [irs_pkg::NumCh];
  logic [31:0] axis_cnt_r, step_cnt_r, back_cnt_r;
  logic [63:0] first_r, last_r;
  logic collecting_r;
  logic [1:0] status_r;

  // serial unit registers
  logic [2:0] ch_r;
  logic step_do_r;
  logic signed [31:0] val_r;
  logic [31:0] n_r;
  logic signed [48:0] delta_r;
  logic [63:0] dm_r;
  logic [63:0] q_r;
  logic [63:0] rem_r;
  logic [6:0] bit_r;
  logic [63:0] mcand_r;
  logic [63:0] mplier_r;
  logic [63:0] prod_r;
  logic ovf_r;
  logic [399:0] odata_r;
  logic [1:0] ouser_r;
  logic ovalid_r;

  logic signed [48:0] scaled;
  logic signed [48:0] dlt2;
  logic [63:0] dm2;
  logic [64:0] rem_sh;
  logic [64:0] prod_add;
  logic [31:0] cur_n;
  logic rd_ok;
  logic [31:0] rd_count;
  logic signed [47:0] rd_mean;
  logic [63:0] rd_spr;
  logic signed [31:0] rd_min;
  logic signed [31:0] rd_max;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;

  always_comb begin
    scaled = {{1{val_r[31]}}, val_r, 16'd0};
    dlt2 = scaled - {mean_r[ch_r][47], mean_r[ch_r]};
    dm2 = dlt2[48] ? 64'(-dlt2) : 64'(dlt2);
    rem_sh = {rem_r, dm_r[63]};
    prod_add = {1'b0, prod_r} + (mplier_r[0] ? {1'b0, mcand_r} : 65'd0);
    cur_n = (ch_r == 3'(irs_pkg::StepCh)) ? step_cnt_r : axis_cnt_r;
    // selected channel for the result item, zero past the last channel
    rd_ok = chsel_r < 3'(irs_pkg::NumCh);
    rd_count = !rd_ok ? 32'd0 : (chsel_r == 3'(irs_pkg::StepCh)) ? step_cnt_r : axis_cnt_r;
    rd_mean = rd_ok ? mean_r[chsel_r] : '0;
    rd_spr = rd_ok ? spr_r[chsel_r] : '0;
    rd_min = rd_ok ? min_r[chsel_r] : '0;
    rd_max = rd_ok ? max_r[chsel_r] : '0;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == '1) ? c : c + 32'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      collecting_r <= 1'b0;
      axis_cnt_r <= '0;
      step_cnt_r <= '0;
      back_cnt_r <= '0;
      first_r <= '0;
      last_r <= '0;
      for (int i = 0; i < irs_pkg::NumCh; i++) begin
        mean_r[i] <= '0;
        spr_r[i] <= '0;
        min_r[i] <= 32'sh7FFFFFFF;
        max_r[i] <= 32'sh80000000;
      end
    end else begin
      // result register handshake
      if (state_r == S_WAIT && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            action_r <= in_tuser[1:0];
            for (int i = 0; i < 6; i++) axis_r[i] <= in_tdata[32*i +: 32];
            finite_r <= in_tuser[2];
            ts_r <= in_tdata[255:192];
            chsel_r <= in_tuser[5:3];
            state_r <= S_CH;
            ch_r <= '0;
          end
        end
        S_CH: begin
          // decode action, set up first channel
          if (action_r == irs_pkg::ACT_SAMPLE && finite_r && collecting_r) begin
            if (first_r == '0) first_r <= ts_r;
            if (last_r != '0 && ts_r > last_r) begin
              step_do_r <= 1'b1;
              step_cnt_r <= sat_inc(step_cnt_r);
              val_r <= ((ts_r - last_r) > 64'h7FFFFFFF) ? 32'sh7FFFFFFF :
                       32'(ts_r - last_r);
            end else begin
              step_do_r <= 1'b0;
              if (last_r != '0) back_cnt_r <= sat_inc(back_cnt_r);
            end
            last_r <= ts_r;
            axis_cnt_r <= sat_inc(axis_cnt_r);
            ch_r <= 3'(irs_pkg::StepCh);
            status_r <= irs_pkg::ST_OK;
            state_r <= S_NEXT;
          end else begin
            state_r <= S_RESULT;
            unique case (action_r)
              irs_pkg::ACT_SAMPLE: begin
                status_r <= finite_r ? irs_pkg::ST_STOPPED : irs_pkg::ST_NONFIN;
              end
              irs_pkg::ACT_CLEAR: begin
                for (int i = 0; i < irs_pkg::NumCh; i++) begin
                  mean_r[i] <= '0;
                  spr_r[i] <= '0;
                  min_r[i] <= 32'sh7FFFFFFF;
                  max_r[i] <= 32'sh80000000;
                end
                axis_cnt_r <= '0;
                step_cnt_r <= '0;
                back_cnt_r <= '0;
                first_r <= '0;
                last_r <= '0;
                collecting_r <= 1'b1;
                status_r <= irs_pkg::ST_CTRL;
              end
              irs_pkg::ACT_STOP: begin
                collecting_r <= 1'b0;
                status_r <= irs_pkg::ST_CTRL;
              end
              // read item
              default: status_r <= irs_pkg::ST_OK;
            endcase
          end
        end
        S_NEXT: begin
          // start divider for channel ch_r, or skip
          if (ch_r == 3'(irs_pkg::StepCh) && !step_do_r) begin
            ch_r <= '0;
            val_r <= axis_r[0];
          end else begin
            n_r <= cur_n;
            delta_r <= dlt2;
            dm_r <= dm2 + 64'(cur_n >> 1);
            rem_r <= '0;
            q_r <= '0;
            bit_r <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= {33'd0, n_r}) begin
            rem_r <= 64'(rem_sh - {33'd0, n_r});
            q_r <= {q_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            q_r <= {q_r[62:0], 1'b0};
          end
          dm_r <= {dm_r[62:0], 1'b0};
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'd63) state_r <= S_MEAN;
        end
        S_MEAN: begin
          mean_r[ch_r] <= delta_r[48] ? mean_r[ch_r] - 48'(q_r) : mean_r[ch_r] + 48'(q_r);
          mcand_r <= delta_r[48] ? 64'(-delta_r) : 64'(delta_r);
          state_r <= S_MUL;
          bit_r <= '0;
          prod_r <= '0;
          ovf_r <= 1'b0;
        end
        S_MUL: begin
          // shift-add multiply, one multiplier bit per cycle
          if (bit_r == 7'd0) begin
            mplier_r <= dm2;
            bit_r <= 7'd1;
          end else begin
            if (prod_add[64] || (mcand_r[63] && mplier_r[63:1] != '0)) ovf_r <= 1'b1;
            prod_r <= prod_add[63:0];
            mcand_r <= {mcand_r[62:0], 1'b0};
            mplier_r <= {1'b0, mplier_r[63:1]};
            if (mplier_r[63:1] == '0) state_r <= S_SUM;
            bit_r <= bit_r + 7'd1;
          end
        end
        S_SUM: begin
          if (ovf_r || (spr_r[ch_r] + prod_r) < prod_r)
            spr_r[ch_r] <= '1;
          else spr_r[ch_r] <= spr_r[ch_r] + prod_r;
          if (val_r < min_r[ch_r]) min_r[ch_r] <= val_r;
          if (val_r > max_r[ch_r]) max_r[ch_r] <= val_r;
          if (ch_r == 3'd5) state_r <= S_RESULT;
          else begin
            ch_r <= (ch_r == 3'(irs_pkg::StepCh)) ? 3'd0 : ch_r + 3'd1;
            val_r <= axis_r[(ch_r == 3'(irs_pkg::StepCh)) ? 3'd0 : 3'(ch_r + 3'd1)];
            state_r <= S_NEXT;
          end
        end
        S_RESULT: begin
          // pass on to S_WAIT, where the result item is assembled
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!ovalid_r || out_tready) begin
            odata_r <= {last_r, first_r, back_cnt_r, rd_max, rd_min, rd_spr, rd_mean,
                        rd_count, axis_cnt_r};
            ouser_r <= status_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/irs_checker.sv */
`timescale 1ns / 1ps
module irs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [399:0] out_tdata,
  input logic [1:0] out_tuser
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  // one item in flight, input stays busy after acceptance
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready [*2])
    else $error("second item taken during work");
  // a valid result carries known bits
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tuser, out_tdata}))
    else $error("unknown bits in result item");
  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
endmodule
bind imu_running_statistics irs_checker u_irs_checker (.*);

/* bench/tb_imu_running_statistics.sv */
`timescale 1ns / 1ps
module tb_imu_running_statistics;

  typedef struct {
    irs_pkg::action_t   action;
    logic signed [31:0] axis [6];
    logic               finite;
    logic [63:0]        ts;
    logic [2:0]         channel;
  } imu_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] samples;
    logic [31:0] ch_count;
    logic [47:0] mean;
    logic [63:0] spread;
    logic [31:0] min_v;
    logic [31:0] max_v;
    logic [31:0] backs;
    logic [63:0] first_ts;
    logic [63:0] last_ts;
  } stats_report_t;

  localparam int WatchdogLimit = 20000;
  localparam int HoldCycles = 400;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [255:0] in_tdata;
  logic [5:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [399:0] out_tdata;
  logic [1:0]   out_tuser;

  imu_running_statistics u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock, period 12 ns
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predicted block state
  longint          mean_acc [irs_pkg::NumCh];
  logic [63:0]     spread_acc [irs_pkg::NumCh];
  logic signed [31:0] min_acc [irs_pkg::NumCh];
  logic signed [31:0] max_acc [irs_pkg::NumCh];
  int unsigned     sample_total;
  int unsigned     step_total;
  int unsigned     backward_total;
  logic [63:0]     first_stamp;
  logic [63:0]     last_stamp;
  bit              collecting;

  stats_report_t   pending_reports [$];
  int              mismatches = 0;
  bit              calm = 1'b0;
  bit              hold_go = 1'b0;
  int              hold_left = 0;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic [63:0]     gen_stamp;

  function automatic int unsigned sat_inc(int unsigned c);
    return (c == 32'hFFFF_FFFF) ? c : c + 1;
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i < irs_pkg::NumCh; i++) begin
      mean_acc[i] = 0;
      spread_acc[i] = '0;
      min_acc[i] = 32'sh7FFF_FFFF;
      max_acc[i] = 32'sh8000_0000;
    end
    sample_total = 0;
    step_total = 0;
    backward_total = 0;
    first_stamp = '0;
    last_stamp = '0;
  endfunction

  // one welford update of a channel with count n
  function automatic void welford_update(int ch, longint value, int unsigned n);
    longint       scaled;
    longint       delta;
    longint       rest;
    logic [63:0]  dm;
    logic [63:0]  dm2;
    logic [63:0]  q;
    logic [127:0] prod_w;
    logic [63:0]  prod;
    logic [64:0]  sum;
    scaled = value * 65536;
    delta = scaled - mean_acc[ch];
    dm = (delta < 0) ? 64'(-delta) : 64'(delta);
    q = (dm + 64'(n / 2)) / 64'(n);
    mean_acc[ch] = (delta < 0) ? mean_acc[ch] - longint'(q) : mean_acc[ch] + longint'(q);
    rest = scaled - mean_acc[ch];
    dm2 = (rest < 0) ? 64'(-rest) : 64'(rest);
    prod_w = {64'd0, dm} * {64'd0, dm2};
    prod = (prod_w[127:64] != 0) ? '1 : prod_w[63:0];
    sum = {1'b0, spread_acc[ch]} + {1'b0, prod};
    spread_acc[ch] = sum[64] ? '1 : sum[63:0];
    if (value < longint'(min_acc[ch])) min_acc[ch] = 32'(value);
    if (value > longint'(max_acc[ch])) max_acc[ch] = 32'(value);
  endfunction

  // apply one item to the predicted state and return the report it causes
  function automatic stats_report_t predict_report(imu_item_t it);
    stats_report_t r;
    logic [1:0]    st;
    logic [63:0]   dt;
    st = irs_pkg::ST_OK;
    case (it.action)
      irs_pkg::ACT_SAMPLE: begin
        if (!it.finite) begin
          st = irs_pkg::ST_NONFIN;
        end else if (!collecting) begin
          st = irs_pkg::ST_STOPPED;
        end else begin
          if (first_stamp == 0) first_stamp = it.ts;
          if (last_stamp != 0) begin
            if (it.ts > last_stamp) begin
              dt = it.ts - last_stamp;
              if (dt > 64'h7FFF_FFFF) dt = 64'h7FFF_FFFF;
              step_total = sat_inc(step_total);
              welford_update(irs_pkg::StepCh, longint'(dt), step_total);
            end else begin
              backward_total = sat_inc(backward_total);
            end
          end
          last_stamp = it.ts;
          sample_total = sat_inc(sample_total);
          for (int i = 0; i < 6; i++) welford_update(i, longint'(it.axis[i]), sample_total);
        end
      end
      irs_pkg::ACT_CLEAR: begin
        clear_stats();
        collecting = 1'b1;
        st = irs_pkg::ST_CTRL;
      end
      irs_pkg::ACT_STOP: begin
        collecting = 1'b0;
        st = irs_pkg::ST_CTRL;
      end
      default: st = irs_pkg::ST_OK;
    endcase
    r.status = st;
    r.samples = sample_total;
    if (it.channel < irs_pkg::NumCh) begin
      r.ch_count = (it.channel == irs_pkg::StepCh) ? step_total : sample_total;
      r.mean = mean_acc[it.channel][47:0];
      r.spread = spread_acc[it.channel];
      r.min_v = min_acc[it.channel];
      r.max_v = max_acc[it.channel];
    end else begin
      r.ch_count = '0;
      r.mean = '0;
      r.spread = '0;
      r.min_v = '0;
      r.max_v = '0;
    end
    r.backs = backward_total;
    r.first_ts = first_stamp;
    r.last_ts = last_stamp;
    return r;
  endfunction

  function automatic logic [255:0] pack_data(imu_item_t it);
    logic [255:0] d;
    d = '0;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = it.axis[i];
    d[255:192] = it.ts;
    return d;
  endfunction

  function automatic logic [5:0] pack_user(imu_item_t it);
    return {it.channel, it.finite, it.action};
  endfunction

  function automatic stats_report_t unpack_report(logic [399:0] d, logic [1:0] u);
    stats_report_t r;
    r.status = u;
    r.samples = d[31:0];
    r.ch_count = d[63:32];
    r.mean = d[111:64];
    r.spread = d[175:112];
    r.min_v = d[207:176];
    r.max_v = d[239:208];
    r.backs = d[271:240];
    r.first_ts = d[335:272];
    r.last_ts = d[399:336];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    stats_report_t got;
    stats_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_report(out_tdata, out_tuser);
      if (pending_reports.size() == 0) begin
        if (mismatches < 10) $display("unexpected result item %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("sample_count", 64'(want.samples), 64'(got.samples));
        check_field("channel_count", 64'(want.ch_count), 64'(got.ch_count));
        check_field("channel_mean", 64'(want.mean), 64'(got.mean));
        check_field("channel_spread", want.spread, got.spread);
        check_field("channel_min", 64'(want.min_v), 64'(got.min_v));
        check_field("channel_max", 64'(want.max_v), 64'(got.max_v));
        check_field("nonmonotonic_count", 64'(want.backs), 64'(got.backs));
        check_field("first_time", want.first_ts, got.first_ts);
        check_field("last_time", want.last_ts, got.last_ts);
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      out_tready <= 1'b0;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_imu_running_statistics: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(imu_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_data(it);
    in_tuser <= pack_user(it);
    do @(posedge clk); while (!in_tready);
    pending_reports.push_back(predict_report(it));
  endtask

  function automatic imu_item_t make_item(irs_pkg::action_t a, logic signed [31:0] v,
                                          logic [63:0] ts, logic [2:0] ch);
    imu_item_t it;
    it.action = a;
    for (int i = 0; i < 6; i++) it.axis[i] = v;
    it.finite = 1'b1;
    it.ts = ts;
    it.channel = ch;
    return it;
  endfunction

  // random sample near a resting value, with occasional wild axes
  function automatic imu_item_t random_sample();
    imu_item_t it;
    int        pick;
    it = make_item(irs_pkg::ACT_SAMPLE, '0, '0, 3'($urandom_range(0, 7)));
    for (int i = 0; i < 6; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) it.axis[i] = $urandom;
      else if (pick == 1) it.axis[i] = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else it.axis[i] = (i == 2 ? 32'sd642_000 : 32'sd0) +
                        $signed($urandom_range(0, 8191)) - 32'sd4096;
    end
    it.finite = ($urandom_range(0, 19) != 0);
    pick = $urandom_range(0, 39);
    if (pick == 0) gen_stamp = '0;
    else if (pick == 1) gen_stamp = {$urandom, $urandom};
    else if (pick == 2) gen_stamp = gen_stamp - 64'($urandom_range(0, 100000));
    else if (pick == 3) gen_stamp = gen_stamp + 64'h1_0000_0000;
    else gen_stamp = gen_stamp + 64'($urandom_range(1, 5_000_000));
    it.ts = gen_stamp;
    return it;
  endfunction

  function automatic imu_item_t random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return random_sample();
    if (pick < 90) return make_item(irs_pkg::ACT_READ, $urandom, {$urandom, $urandom},
                                    3'($urandom_range(0, 7)));
    if (pick < 95) return make_item(irs_pkg::ACT_CLEAR, $urandom, {$urandom, $urandom},
                                    3'($urandom_range(0, 7)));
    return make_item(irs_pkg::ACT_STOP, $urandom, {$urandom, $urandom},
                     3'($urandom_range(0, 7)));
  endfunction

  // empty channels, samples while stopped, stop while stopped
  task automatic test_idle_reads();
    imu_item_t it;
    for (int c = 0; c < 8; c++) send_item(make_item(irs_pkg::ACT_READ, '0, '0, 3'(c)));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sd5, 64'd100, 3'd0));
    it = make_item(irs_pkg::ACT_SAMPLE, 32'sd5, 64'd100, 3'd1);
    it.finite = 1'b0;
    send_item(it);
    send_item(make_item(irs_pkg::ACT_STOP, '0, '0, 3'd2));
  endtask

  // extremes, timestamp cases, clear while collecting
  task automatic test_directed();
    imu_item_t it;
    send_item(make_item(irs_pkg::ACT_CLEAR, '0, '0, 3'd0));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sh7FFF_FFFF, 64'd0, 3'd0));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sh8000_0000, 64'd1000, 3'd1));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sh7FFF_FFFF, 64'd2000, 3'd6));
    send_item(make_item(irs_pkg::ACT_SAMPLE, '0, 64'd2000, 3'd6));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sd1, 64'd1500, 3'd6));
    send_item(make_item(irs_pkg::ACT_SAMPLE, -32'sd1, 64'hFFFF_FFFF_FFFF_FFFF, 3'd6));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sh5555_5555, 64'd0, 3'd7));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'shAAAA_AAAA, 64'd7, 3'd6));
    it = make_item(irs_pkg::ACT_SAMPLE, 32'sd9, 64'd8, 3'd2);
    it.finite = 1'b0;
    send_item(it);
    for (int c = 0; c < 8; c++) send_item(make_item(irs_pkg::ACT_READ, '0, '0, 3'(c)));
    send_item(make_item(irs_pkg::ACT_CLEAR, '0, '0, 3'd6));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sd3, 64'd50, 3'd3));
    send_item(make_item(irs_pkg::ACT_STOP, '0, '0, 3'd3));
    send_item(make_item(irs_pkg::ACT_SAMPLE, 32'sd3, 64'd60, 3'd3));
  endtask

  // receiver holds off while reads keep coming, so input stalls
  task automatic test_backpressure();
    send_item(make_item(irs_pkg::ACT_CLEAR, '0, '0, 3'd0));
    in_tvalid <= 1'b0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 20; i++)
      send_item(make_item(irs_pkg::ACT_READ, '0, '0, 3'($urandom_range(0, 7))));
  endtask

  task automatic test_random(int count);
    send_item(make_item(irs_pkg::ACT_CLEAR, '0, '0, 3'd0));
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    gen_stamp = 64'd1_000_000;
    collecting = 1'b0;
    clear_stats();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_reads();
    test_directed();
    test_backpressure();
    test_random(1200);
    calm = 1'b1;
    test_random(300);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_imu_running_statistics: done, clean");
    end else begin
      $display("tb_imu_running_statistics: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/irs_pkg.sv
sv/imu_running_statistics.sv
sv/irs_checker.sv
bench/tb_imu_running_statistics.sv
